// ----- sv/wnm_pkg.sv -----
// ----------------------------------------------------------------------------
// wnm_pkg
// shared types and constants of the wildcard name matcher
// ----------------------------------------------------------------------------
package wnm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_BITS   = 128;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

  localparam int LEN_REG_W = 5;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       end_of_name;
  } in_word_t;

  typedef struct packed {
    logic name_matches;
  } out_word_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// ----- sv/wnm_stream_if.sv -----
// ----------------------------------------------------------------------------
// wnm_stream_if
// valid/ready channel carrying one word of type word_t
// ----------------------------------------------------------------------------
interface wnm_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/wnm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wnm_cfg_regs
// pattern registers with saturated pattern length
// ----------------------------------------------------------------------------
module wnm_cfg_regs #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [8*MAX_PATTERN-1:0]      pattern,
  output logic [LEN_W-1:0]              eff_len
);
  import wnm_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_REG_W-1:0]  pattern_len;
  logic [PAT_BITS-1:0]   pattern_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data;
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_all = {pattern_high, pattern_low};
  assign pattern     = pattern_all[8*MAX_PATTERN-1:0];

  // length above the pattern capacity saturates
  assign eff_len = (pattern_len > LEN_REG_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                           : LEN_W'(pattern_len);
endmodule

// ----- sv/wnm_row_step.sv -----
// ----------------------------------------------------------------------------
// wnm_row_step
// one update of the match row for one name byte
// ----------------------------------------------------------------------------
module wnm_row_step #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
  parameter int ROW_W       = MAX_PATTERN + 1
) (
  input  logic [8*MAX_PATTERN-1:0] pattern,
  input  logic [LEN_W-1:0]         eff_len,
  input  logic [ROW_W-1:0]         prev_row,
  input  logic                     at_start,
  input  logic [7:0]               name_byte,
  input  logic                     byte_valid,
  output logic [ROW_W-1:0]         row
);
  import wnm_pkg::*;

  logic [ROW_W-1:0] start_row;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] stepped;
  logic [7:0]       lc;

  // start row: leading stars can match the empty prefix
  always_comb begin
    start_row    = '0;
    start_row[0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (LEN_W'(j) <= eff_len && pattern[8*(j-1) +: 8] == STAR_CHAR && start_row[j-1]) begin
        start_row[j] = 1'b1;
      end
    end
  end

  assign cur_row = at_start ? start_row : prev_row;
  assign lc      = lower_ascii(name_byte);

  always_comb begin
    logic [7:0] p;
    stepped = '0;
    p       = '0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      p = pattern[8*(j-1) +: 8];
      if (LEN_W'(j) <= eff_len) begin
        if (p == STAR_CHAR) begin
          stepped[j] = stepped[j-1] | cur_row[j];
        end else if (p == QMARK_CHAR) begin
          stepped[j] = cur_row[j-1];
        end else begin
          stepped[j] = cur_row[j-1] & (lower_ascii(p) == lc);
        end
      end
    end
  end

  assign row = byte_valid ? stepped : cur_row;
endmodule

// ----- sv/wildcard_name_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_name_matcher
// case-insensitive '*' / '?' matcher over a streamed name
// ----------------------------------------------------------------------------
//  channel  dir  word        accepted when
//  chars    in   in_word_t   chars.valid & chars.ready
//  verdict  out  out_word_t  verdict.valid & verdict.ready
//  cfg_*    in   64b write   cfg_we
//
//  one word per cycle unless an end-of-name word waits on a stalled verdict;
//  a word is registered in the input stage, then its verdict in the output register
//  the row update is one pass of prefix logic over the pattern positions
//  reset clears the pattern registers, the row and both valid flags
//  a stalled verdict holds the input stage only for an end-of-name word
// ----------------------------------------------------------------------------
module wildcard_name_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  wnm_stream_if.sink                    chars,
  wnm_stream_if.source                  verdict,
  input  logic                          cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wnm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int ROW_W = MAX_PATTERN + 1;

  logic [8*MAX_PATTERN-1:0] pattern;
  logic [LEN_W-1:0]         eff_len;

  logic                     s1_valid;
  in_word_t                 s1_word;
  logic                     s1_adv;
  logic                     s1_fire;

  logic [ROW_W-1:0]         match_row;
  logic                     at_name_start;
  logic [ROW_W-1:0]         row;

  logic                     out_valid;
  out_word_t                out_word;

  wnm_cfg_regs #(.MAX_PATTERN(MAX_PATTERN), .LEN_W(LEN_W)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pattern   (pattern),
    .eff_len   (eff_len)
  );

  wnm_row_step #(.MAX_PATTERN(MAX_PATTERN), .LEN_W(LEN_W), .ROW_W(ROW_W)) u_step (
    .pattern    (pattern),
    .eff_len    (eff_len),
    .prev_row   (match_row),
    .at_start   (at_name_start),
    .name_byte  (s1_word.name_byte),
    .byte_valid (s1_word.byte_valid),
    .row        (row)
  );

  // only an end word needs room in the output register
  assign s1_adv      = !s1_word.end_of_name || !out_valid || verdict.ready;
  assign s1_fire     = s1_valid && s1_adv;
  assign chars.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_word <= chars.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_row     <= '0;
      at_name_start <= 1'b1;
    end else if (s1_fire) begin
      if (s1_word.end_of_name) begin
        match_row     <= '0;
        at_name_start <= 1'b1;
      end else if (s1_word.byte_valid) begin
        match_row     <= row;
        at_name_start <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_word.end_of_name) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_word.end_of_name) begin
      out_word.name_matches <= row[eff_len];
    end
  end

  assign verdict.valid = out_valid;
  assign verdict.data  = out_word;

`ifndef SYNTHESIS
  a_start_row_clear: assert property (@(posedge clk) disable iff (rst)
    at_name_start |-> match_row == '0)
    else $error("row not clear at name start");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_word.end_of_name |=> at_name_start && out_valid)
    else $error("end word did not restart the row or load a verdict");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_word.end_of_name))
    else $error("verdict without an end word");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_word) && $stable(match_row))
    else $error("stalled input stage changed");
`endif
endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the wildcard name matcher: a short directed list of
// patterns and names, then random patterns with names built to match them,
// near misses and noise; every verdict word is checked against a value pinned in
// the directed list or against a model of the match row kept in the bench
// ----------------------------------------------------------------------------
module testbench;
  import wnm_pkg::*;

  localparam int PAT_MAX      = 16;
  localparam int ITEM_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 3000;

  localparam logic [7:0] NAME_SET [8] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h7A, 8'h40,
                                          8'h5B, 8'h60};
  localparam logic [7:0] PAT_SET [8]  = '{8'h61, 8'h42, 8'h7A, STAR_CHAR, QMARK_CHAR,
                                          STAR_CHAR, 8'h40, 8'h7B};

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_word_t              word;
    bit                    pinned;
    bit                    pinned_val;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wnm_stream_if #(.word_t(in_word_t))  chars ();
  wnm_stream_if #(.word_t(out_word_t)) verdict ();

  // bench copy of pattern registers and match row
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [4:0]  pat_len_q = '0;
  logic [16:0] row_q = '0;
  bit          at_start_q = 1'b1;

  bit verdicts_due[$];
  int errors = 0;
  int items_sent = 0;
  bit send_calm = 1'b0;
  bit drain_calm = 1'b0;
  bit hold_req = 1'b0;

  wildcard_name_matcher #(.MAX_PATTERN(PAT_MAX)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .verdict   (verdict),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int used_len();
    return (pat_len_q > PAT_MAX) ? PAT_MAX : int'(pat_len_q);
  endfunction

  function automatic logic [7:0] pat_at(int k);
    return (k < 8) ? pat_lo_q[8*k +: 8] : pat_hi_q[8*(k-8) +: 8];
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [16:0] initial_row();
    logic [16:0] row;
    row = 17'd1;
    for (int j = 1; j <= used_len(); j++) begin
      if (pat_at(j-1) == STAR_CHAR && row[j-1]) row[j] = 1'b1;
    end
    return row;
  endfunction

  function automatic logic [16:0] next_row(logic [16:0] prev, logic [7:0] ch);
    logic [16:0] nxt;
    logic [7:0]  p;
    nxt = '0;
    for (int j = 1; j <= used_len(); j++) begin
      p = pat_at(j-1);
      if (p == STAR_CHAR) begin
        nxt[j] = nxt[j-1] | prev[j];
      end else if (p == QMARK_CHAR) begin
        nxt[j] = prev[j-1];
      end else begin
        nxt[j] = prev[j-1] & (fold_case(p) == fold_case(ch));
      end
    end
    return nxt;
  endfunction

  task automatic advance_matcher(input in_word_t w, output bit fires, output bit matched);
    logic [16:0] row;
    fires = 1'b0;
    matched = 1'b0;
    if (!w.byte_valid && !w.end_of_name) return;
    row = at_start_q ? initial_row() : row_q;
    if (w.byte_valid) begin
      row = next_row(row, w.name_byte);
      row_q = row;
      at_start_q = 1'b0;
    end
    if (w.end_of_name) begin
      fires = 1'b1;
      matched = row[used_len()];
      row_q = '0;
      at_start_q = 1'b1;
    end
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] name_char();
    return NAME_SET[$urandom_range(0, 7)];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PATTERN_LOW:  pat_lo_q = val;
      REG_PATTERN_HIGH: pat_hi_q = val;
      REG_PATTERN_LEN:  pat_len_q = val[LEN_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input in_word_t w, input bit pinned, input bit pinned_val);
    int gap;
    bit fires;
    bit matched;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars.valid <= 1'b1;
    chars.data <= w;
    do @(posedge clk); while (!chars.ready);
    advance_matcher(w, fires, matched);
    if (fires) verdicts_due = {verdicts_due, (pinned ? pinned_val : matched)};
    if (w.byte_valid || w.end_of_name) items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    chars.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_name(input text_q_t text);
    in_word_t w;
    bit       marker;
    marker = (text.size() == 0) || ($urandom_range(0, 1) == 1);
    foreach (text[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        w.name_byte = 8'($urandom_range(0, 255));
        w.byte_valid = 1'b0;
        w.end_of_name = 1'b0;
        send_word(w, 1'b0, 1'b0);
      end
      w.name_byte = text[i];
      w.byte_valid = 1'b1;
      w.end_of_name = !marker && (i == text.size() - 1);
      send_word(w, 1'b0, 1'b0);
    end
    if (marker) begin
      w.name_byte = 8'($urandom_range(0, 255));
      w.byte_valid = 1'b0;
      w.end_of_name = 1'b1;
      send_word(w, 1'b0, 1'b0);
    end
  endtask

  // mostly names that fit the pattern, then near misses and noise
  task automatic compose_name(output text_q_t text);
    int r;
    logic [7:0] p;
    text = {};
    r = $urandom_range(0, 99);
    if (r < 60) begin
      for (int k = 0; k < used_len(); k++) begin
        p = pat_at(k);
        if (p == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) text = {text, name_char()};
        end else if (p == QMARK_CHAR) begin
          text = {text, 8'($urandom_range(0, 255))};
        end else if (((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A))
                     && $urandom_range(0, 1) == 1) begin
          text = {text, p ^ 8'h20};
        end else begin
          text = {text, p};
        end
      end
      if (r >= 50 && text.size() > 0) text[$urandom_range(0, text.size() - 1)] = name_char();
    end else if (r < 85) begin
      repeat ($urandom_range(0, 8)) text = {text, name_char()};
    end else begin
      repeat ($urandom_range(0, 6)) text = {text, 8'($urandom_range(0, 255))};
    end
  endtask

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t word_row(logic [7:0] b, bit v, bit e);
    step_t s;
    s = '{default: '0};
    s.word.name_byte = b;
    s.word.byte_valid = v;
    s.word.end_of_name = e;
    return s;
  endfunction

  function automatic step_t known_row(logic [7:0] b, bit v, bit e, bit want);
    step_t s;
    s = word_row(b, v, e);
    s.pinned = 1'b1;
    s.pinned_val = want;
    return s;
  endfunction

  // verdict checker
  always @(posedge clk) begin
    if (!rst && verdict.valid && verdict.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: expected no word, actual name_matches=%0b", $time,
                 verdict.data.name_matches);
        errors++;
      end else if (verdict.data.name_matches !== verdicts_due[0]) begin
        $display("%0t: expected name_matches=%0b, actual %0b", $time, verdicts_due[0],
                 verdict.data.name_matches);
        errors++;
        void'(verdicts_due.pop_front());
      end else begin
        void'(verdicts_due.pop_front());
      end
    end
  end

  // verdict ready with random stalls and one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    verdict.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        verdict.ready <= 1'b0;
        stall_left--;
      end else begin
        verdict.ready <= 1'b1;
        stall_left = pick_gap(drain_calm);
      end
    end
  end

  // watchdog on cycles with no traffic
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((chars.valid && chars.ready) || (verdict.valid && verdict.ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_t       plan[$];
    text_q_t     text;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    logic [7:0]  b;
    int          phase;
    int          r;
    int          names;

    chars.valid <= 1'b0;
    chars.data <= '0;

    // empty pattern after reset
    plan = {plan, known_row(8'h00, 1'b0, 1'b1, 1'b1)};
    plan = {plan, known_row(8'h61, 1'b1, 1'b1, 1'b0)};
    plan = {plan, word_row(8'hFF, 1'b0, 1'b0)};
    // "A*?b"
    plan = {plan, cfg_row(REG_PATTERN_LOW, 64'h0000_0000_623F_2A41)};
    plan = {plan, cfg_row(REG_PATTERN_HIGH, 64'h0)};
    plan = {plan, cfg_row(REG_PATTERN_LEN, 64'd4)};
    plan = {plan, word_row(8'h61, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h78, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h79, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h42, 1'b1, 1'b1)};
    plan = {plan, word_row(8'h41, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h62, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h00, 1'b0, 1'b1)};
    // sixteen stars
    plan = {plan, cfg_row(REG_PATTERN_LOW, 64'h2A2A_2A2A_2A2A_2A2A)};
    plan = {plan, cfg_row(REG_PATTERN_HIGH, 64'h2A2A_2A2A_2A2A_2A2A)};
    plan = {plan, cfg_row(REG_PATTERN_LEN, 64'd16)};
    plan = {plan, known_row(8'h00, 1'b0, 1'b1, 1'b1)};
    plan = {plan, known_row(8'h00, 1'b1, 1'b1, 1'b1)};
    plan = {plan, word_row(8'hFF, 1'b1, 1'b1)};
    // fifteen stars then 'z', length saturates at sixteen
    plan = {plan, cfg_row(REG_PATTERN_HIGH, 64'h7A2A_2A2A_2A2A_2A2A)};
    plan = {plan, cfg_row(REG_PATTERN_LEN, 64'd31)};
    plan = {plan, known_row(8'h00, 1'b0, 1'b1, 1'b0)};
    plan = {plan, known_row(8'h5A, 1'b1, 1'b1, 1'b1)};
    plan = {plan, word_row(8'hFF, 1'b1, 1'b0)};
    plan = {plan, word_row(8'h7A, 1'b1, 1'b1)};
    // single '?'
    plan = {plan, cfg_row(REG_PATTERN_LOW, 64'h3F)};
    plan = {plan, cfg_row(REG_PATTERN_LEN, 64'd1)};
    plan = {plan, word_row(8'h80, 1'b1, 1'b1)};
    plan = {plan, word_row(8'h00, 1'b0, 1'b1)};
    // pattern rewritten in mid-name
    plan = {plan, cfg_row(REG_PATTERN_LOW, 64'h6261)};
    plan = {plan, cfg_row(REG_PATTERN_LEN, 64'd2)};
    plan = {plan, word_row(8'h41, 1'b1, 1'b0)};
    plan = {plan, cfg_row(REG_PATTERN_LOW, 64'h6278)};
    plan = {plan, word_row(8'h42, 1'b1, 1'b1)};

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].word, plan[i].pinned, plan[i].pinned_val);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      for (int k = 0; k < 16; k++) begin
        b = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                         : PAT_SET[$urandom_range(0, 7)];
        if (k < 8) lo[8*k +: 8] = b;
        else hi[8*(k-8) +: 8] = b;
      end
      r = $urandom_range(0, 99);
      len_word = (r < 8)  ? 64'd0 :
                 (r < 18) ? 64'd16 :
                 (r < 24) ? 64'($urandom_range(17, 31)) : 64'($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0) len_word = len_word | ({$urandom, $urandom} & ~64'h1F);
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LEN, len_word);

      send_calm = ($urandom_range(0, 3) == 0);
      drain_calm = ($urandom_range(0, 3) == 0);
      names = $urandom_range(4, 12);
      // receiver holds off while names keep coming back to back
      if (phase == 2 || phase == 12) begin
        send_calm = 1'b1;
        hold_req = 1'b1;
        names = 30;
      end
      repeat (names) begin
        compose_name(text);
        send_name(text);
      end
      phase++;
    end

    settle();
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wnm_pkg.sv
sv/wnm_stream_if.sv
sv/wnm_cfg_regs.sv
sv/wnm_row_step.sv
sv/wildcard_name_matcher.sv
verif/testbench.sv
